[rtl/olsup_pkg.sv]
// ----------------------------------------------------------------------------
// Oscillator lock supervisor package
// Shared payload types, configuration layout and state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package olsup_pkg;

  // Supervisor state codes
  localparam logic [3:0] StStartup    = 4'd0;
  localparam logic [3:0] StSetup      = 4'd1;
  localparam logic [3:0] StError      = 4'd2;
  localparam logic [3:0] StFixed      = 4'd3;
  localparam logic [3:0] StLocking    = 4'd4;
  localparam logic [3:0] StLocked     = 4'd5;
  localparam logic [3:0] StLost       = 4'd6;
  localparam logic [3:0] StOutOfPhase = 4'd7;
  localparam logic [3:0] StHoldFixed  = 4'd8;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgPhaseTol   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLockSecs   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDefaultDac = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgVideoStd   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSetupWait  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgValidWait  = 3'd5;

  localparam int unsigned CfgDataW = 16;

  // Configuration reset values
  localparam logic [14:0] PhaseTolReset   = 15'd40;
  localparam logic [12:0] LockSecsReset   = 13'd30;
  localparam logic [15:0] DefaultDacReset = 16'd18260;
  localparam logic        VideoStdReset   = 1'b0;
  localparam logic [7:0]  SetupWaitReset  = 8'd5;
  localparam logic [7:0]  ValidWaitReset  = 8'd3;

  // Control bit masks
  localparam logic [4:0] CtrlStd   = 5'h01;
  localparam logic [4:0] CtrlReset = 5'h04;
  localparam logic [4:0] CtrlFast  = 5'h08;
  localparam logic [4:0] CtrlFixed = 5'h10;

  // Blink patterns
  localparam logic [7:0] PatAllOn   = 8'hFF;
  localparam logic [7:0] PatOff     = 8'h00;
  localparam logic [7:0] PatFixed   = 8'h33;
  localparam logic [7:0] PatLocking = 8'h01;
  localparam logic [7:0] PatLost    = 8'h05;
  localparam logic [7:0] PatOop     = 8'h15;

  localparam logic [15:0] SecsMax = 16'hFFFF;

  typedef struct packed {
    logic        pps_rise;
    logic        timepulse_ok;
    logic signed [15:0] phase_error;
    logic [15:0] dac_sample;
    logic        setup_ok;
    logic        restart;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  sup_state;
    logic [4:0]  osc_control;
    logic        control_write;
    logic        locked_flag;
    logic        dac_write;
    logic [15:0] dac_word;
    logic [15:0] avg_dac;
    logic [7:0]  blink_pattern;
  } out_item_t;

  typedef struct packed {
    logic [14:0] phase_tolerance;
    logic [12:0] lock_seconds;
    logic [16:0] hold_limit;
    logic [15:0] default_dac;
    logic        video_standard;
    logic [7:0]  setup_wait;
    logic [7:0]  valid_wait;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/olsup_cfg.sv]
// ----------------------------------------------------------------------------
// Oscillator lock supervisor configuration registers
// Holds the six setup registers and derives the holdover limit.
// ----------------------------------------------------------------------------
`default_nettype none

module olsup_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [olsup_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [olsup_pkg::CfgDataW-1:0] cfg_data_i,
  output      logic                          cfg_ready_o,
  output      olsup_pkg::cfg_t               cfg_o
);

  logic [14:0] phase_tol_q;
  logic [12:0] lock_secs_q;
  logic [15:0] default_dac_q;
  logic        video_std_q;
  logic [7:0]  setup_wait_q;
  logic [7:0]  valid_wait_q;

  // The register file takes a write in every cycle.
  assign cfg_ready_o = 1'b1;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_tol_q   <= olsup_pkg::PhaseTolReset;
      lock_secs_q   <= olsup_pkg::LockSecsReset;
      default_dac_q <= olsup_pkg::DefaultDacReset;
      video_std_q   <= olsup_pkg::VideoStdReset;
      setup_wait_q  <= olsup_pkg::SetupWaitReset;
      valid_wait_q  <= olsup_pkg::ValidWaitReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        olsup_pkg::CfgPhaseTol:   phase_tol_q   <= cfg_data_i[14:0];
        olsup_pkg::CfgLockSecs:   lock_secs_q   <= cfg_data_i[12:0];
        olsup_pkg::CfgDefaultDac: default_dac_q <= cfg_data_i;
        olsup_pkg::CfgVideoStd:   video_std_q   <= cfg_data_i[0];
        olsup_pkg::CfgSetupWait:  setup_wait_q  <= cfg_data_i[7:0];
        olsup_pkg::CfgValidWait:  valid_wait_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Holdover limit is ten times the lock time: (x << 3) + (x << 1).
  always_comb begin
    cfg_o.phase_tolerance = phase_tol_q;
    cfg_o.lock_seconds    = lock_secs_q;
    cfg_o.hold_limit      = {1'b0, lock_secs_q, 3'b000} + {3'b000, lock_secs_q, 1'b0};
    cfg_o.default_dac     = default_dac_q;
    cfg_o.video_standard  = video_std_q;
    cfg_o.setup_wait      = setup_wait_q;
    cfg_o.valid_wait      = valid_wait_q;
  end

endmodule

`default_nettype wire

[rtl/olsup_core.sv]
// ----------------------------------------------------------------------------
// Oscillator lock supervisor core
// Supervisor state and the single-pass update for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module olsup_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire olsup_pkg::in_item_t  item_i,
  input  wire olsup_pkg::cfg_t      cfg_i,
  output      olsup_pkg::out_item_t res_o
);

  logic [3:0]         cur_q, cur_d;
  logic [3:0]         pend_q, pend_d;
  logic [15:0]        secs_q, secs_d;
  logic signed [15:0] held_q, held_d;
  logic [15:0]        avg_q, avg_d;
  logic [4:0]         ctrl_q, ctrl_d;
  logic               lock_q, lock_d;
  logic [7:0]         pat_q, pat_d;
  logic               dac_wr;
  logic [15:0]        dac_val;
  logic signed [16:0] tol_pos;
  logic signed [16:0] tol_neg;
  logic signed [16:0] held_ext;
  logic               in_tol;
  logic               out_tol;

  // Tolerance window compares work on the phase as it stands after sampling.
  assign tol_pos  = $signed({2'b00, cfg_i.phase_tolerance});
  assign tol_neg  = -tol_pos;
  assign held_ext = {held_d[15], held_d};
  assign in_tol   = (held_ext < tol_pos) && (held_ext > tol_neg);
  assign out_tol  = (held_ext > tol_pos) || (held_ext < tol_neg);

  // Restart, pulse sampling, entry actions, then transitions.
  always_comb begin
    cur_d   = cur_q;
    pend_d  = pend_q;
    secs_d  = secs_q;
    held_d  = held_q;
    avg_d   = avg_q;
    ctrl_d  = ctrl_q;
    lock_d  = lock_q;
    pat_d   = pat_q;
    dac_wr  = 1'b0;
    dac_val = '0;

    if (item_i.restart) begin
      pend_d = olsup_pkg::StStartup;
      cur_d  = olsup_pkg::StSetup;
    end

    // Pulse sampling: latch the phase, average while locked, count seconds.
    if (item_i.pps_rise) begin
      held_d = item_i.phase_error;
      if (cur_d == olsup_pkg::StLocked) begin
        avg_d = avg_q - {4'b0000, avg_q[15:4]} + {4'b0000, item_i.dac_sample[15:4]};
      end
      if (secs_q != olsup_pkg::SecsMax) begin
        secs_d = secs_q + 16'd1;
      end
    end

    // Entry actions of a newly requested state.
    if (cur_d != pend_d) begin
      case (pend_d)
        olsup_pkg::StStartup: begin
          pat_d   = olsup_pkg::PatAllOn;
          dac_wr  = 1'b1;
          dac_val = '0;
          avg_d   = cfg_i.default_dac;
          ctrl_d  = ({4'b0000, cfg_i.video_standard} & olsup_pkg::CtrlStd)
                    | olsup_pkg::CtrlReset | olsup_pkg::CtrlFast;
        end
        olsup_pkg::StSetup: begin
          pat_d = olsup_pkg::PatOff;
        end
        olsup_pkg::StError: begin
          pat_d = olsup_pkg::PatAllOn;
        end
        olsup_pkg::StFixed: begin
          pat_d   = olsup_pkg::PatFixed;
          lock_d  = 1'b0;
          dac_wr  = 1'b1;
          dac_val = avg_d;
          ctrl_d  = ctrl_d | olsup_pkg::CtrlFixed;
        end
        olsup_pkg::StLocking: begin
          pat_d  = olsup_pkg::PatLocking;
          lock_d = 1'b0;
          ctrl_d = (ctrl_d & ~(olsup_pkg::CtrlFixed | olsup_pkg::CtrlReset))
                   | olsup_pkg::CtrlFast;
        end
        olsup_pkg::StLocked: begin
          pat_d  = olsup_pkg::PatOff;
          lock_d = 1'b1;
          ctrl_d = ctrl_d & ~(olsup_pkg::CtrlFixed | olsup_pkg::CtrlFast);
        end
        olsup_pkg::StLost: begin
          pat_d   = olsup_pkg::PatLost;
          dac_wr  = 1'b1;
          dac_val = avg_d;
          ctrl_d  = ctrl_d | olsup_pkg::CtrlFixed;
        end
        olsup_pkg::StOutOfPhase: begin
          pat_d = olsup_pkg::PatOop;
        end
        olsup_pkg::StHoldFixed: begin
          pat_d  = olsup_pkg::PatAllOn;
          lock_d = 1'b0;
          ctrl_d = ctrl_d | olsup_pkg::CtrlFixed;
        end
        default: ;
      endcase
      secs_d = '0;
      cur_d  = pend_d;
    end

    // Transitions from the current state.
    unique case (cur_d)
      olsup_pkg::StStartup: begin
        pend_d = olsup_pkg::StSetup;
      end
      olsup_pkg::StSetup: begin
        if (secs_d > {8'h00, cfg_i.setup_wait}) begin
          pend_d = item_i.setup_ok ? olsup_pkg::StFixed : olsup_pkg::StError;
        end
      end
      olsup_pkg::StError: begin
        pend_d = olsup_pkg::StError;
      end
      olsup_pkg::StFixed: begin
        if (item_i.timepulse_ok) begin
          if (secs_d > {8'h00, cfg_i.valid_wait}) begin
            pend_d = olsup_pkg::StLocking;
          end
        end else begin
          secs_d = '0;
        end
      end
      olsup_pkg::StLocking: begin
        if (!item_i.timepulse_ok) begin
          pend_d = olsup_pkg::StFixed;
        end else if (in_tol) begin
          if (secs_d > {3'b000, cfg_i.lock_seconds}) begin
            pend_d = olsup_pkg::StLocked;
          end
        end else begin
          secs_d = '0;
        end
      end
      olsup_pkg::StLocked: begin
        if (!item_i.timepulse_ok) begin
          pend_d = olsup_pkg::StLost;
        end else if (out_tol) begin
          pend_d = olsup_pkg::StOutOfPhase;
        end
      end
      olsup_pkg::StLost: begin
        if (item_i.timepulse_ok) begin
          pend_d = olsup_pkg::StLocked;
        end else if ({1'b0, secs_d} > cfg_i.hold_limit) begin
          pend_d = olsup_pkg::StHoldFixed;
        end
      end
      olsup_pkg::StOutOfPhase: begin
        if (in_tol) begin
          pend_d = olsup_pkg::StLocked;
        end else if (!item_i.timepulse_ok) begin
          pend_d = olsup_pkg::StLost;
        end else if ({1'b0, secs_d} > cfg_i.hold_limit) begin
          pend_d = olsup_pkg::StLocking;
        end
      end
      olsup_pkg::StHoldFixed: begin
        if (item_i.timepulse_ok) begin
          pend_d = olsup_pkg::StLocking;
        end
      end
      default: begin
        pend_d = olsup_pkg::StError;
      end
    endcase
  end

  // Supervisor state advances once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= olsup_pkg::StSetup;
      pend_q <= olsup_pkg::StStartup;
      secs_q <= '0;
      held_q <= '0;
      avg_q  <= '0;
      ctrl_q <= '0;
      lock_q <= 1'b0;
      pat_q  <= '0;
    end else if (adv_i) begin
      cur_q  <= cur_d;
      pend_q <= pend_d;
      secs_q <= secs_d;
      held_q <= held_d;
      avg_q  <= avg_d;
      ctrl_q <= ctrl_d;
      lock_q <= lock_d;
      pat_q  <= pat_d;
    end
  end

  // Result of this pass.
  always_comb begin
    res_o.sup_state     = cur_d;
    res_o.osc_control   = ctrl_d;
    res_o.control_write = item_i.pps_rise;
    res_o.locked_flag   = lock_d;
    res_o.dac_write     = dac_wr;
    res_o.dac_word      = dac_val;
    res_o.avg_dac       = avg_d;
    res_o.blink_pattern = pat_d;
  end

  // The error state is only left through a restart.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && cur_q == olsup_pkg::StError && !item_i.restart
    |=> cur_q == olsup_pkg::StError)
    else $error("error state left without restart");

  // State holds while no request is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(cur_q) && $stable(pend_q) && $stable(secs_q))
    else $error("supervisor state changed without a request");

  // Only defined state codes are ever held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= olsup_pkg::StHoldFixed && pend_q <= olsup_pkg::StHoldFixed)
    else $error("undefined supervisor state code");

  // A DAC write only happens on entry to start-up, fixed or lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && dac_wr |-> cur_d != cur_q || item_i.restart)
    else $error("DAC write without a state entry");

endmodule

`default_nettype wire

[rtl/oscillator_lock_supervisor.sv]
// ----------------------------------------------------------------------------
// Oscillator lock supervisor
// Input register, single-pass supervisor update and result register.
// ----------------------------------------------------------------------------
// The supervisor takes one request per clock and returns one result per
// request: the request is captured in an input register, the whole
// supervisor pass runs as combinational logic, and the result lands in an
// output register. Both registers move together, so a new request is
// accepted in every cycle while the result side is not stalled; a stalled
// result holds the pipe and raises in_stall_o only when the input register
// is also full. Configuration writes are taken in any cycle and should be
// issued only while no request is in flight.
`default_nettype none

module oscillator_lock_supervisor (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire olsup_pkg::in_item_t            in_data_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      olsup_pkg::out_item_t           out_data_o,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [olsup_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [olsup_pkg::CfgDataW-1:0] cfg_data_i
);

  olsup_pkg::cfg_t      cfg;
  olsup_pkg::in_item_t  item_q;
  olsup_pkg::out_item_t res;
  olsup_pkg::out_item_t res_q;
  logic                 item_vld_q, item_vld_d;
  logic                 res_vld_q, res_vld_d;
  logic                 adv;
  logic                 load;

  olsup_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  olsup_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Pipeline flow control.
  assign adv        = item_vld_q && !(res_vld_q && out_stall_i);
  assign in_stall_o = item_vld_q && !adv;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    item_vld_d = item_vld_q;
    if (load) begin
      item_vld_d = 1'b1;
    end else if (adv) begin
      item_vld_d = 1'b0;
    end
    res_vld_d = res_vld_q;
    if (adv) begin
      res_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      res_vld_d = 1'b0;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_data_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

  // A stall on the input only comes from a full pipe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item_vld_q && res_vld_q && out_stall_i)
    else $error("input stalled with room in the pipe");

  // A request held in the input register is never dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q && !adv |=> item_vld_q)
    else $error("pending request lost");

  // Every processed request produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> res_vld_q)
    else $error("processed request produced no result");

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// Oscillator lock supervisor testbench
// Drives supervisor passes through the request channel, predicts every status
// result with an independent model of the lock state machine, and compares
// the results field by field under several idle and stall mixes. Settings
// are reprogrammed between phases, and one long run walks the longest setup
// wait before locking.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned SendIdle[4] = '{0, 85, 0, 9};
  localparam int unsigned RecvStall[4] = '{0, 0, 85, 9};

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  olsup_pkg::in_item_t            in_data_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  olsup_pkg::out_item_t           out_data_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [olsup_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [olsup_pkg::CfgDataW-1:0] cfg_data_i = '0;

  // Pending passes, expected status and bookkeeping.
  olsup_pkg::in_item_t  pass_queue[$];
  olsup_pkg::out_item_t status_due[$];
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Mirror of the settings and of the supervisor state.
  olsup_pkg::cfg_t    settings;
  logic [3:0]         sup_cur;
  logic [3:0]         sup_next;
  logic [15:0]        pulse_secs;
  logic signed [15:0] latched_phase;
  logic [15:0]        dac_avg;
  logic [4:0]         osc_ctrl;
  logic               lock_seen;
  logic [7:0]         blink;

  oscillator_lock_supervisor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // One supervisor pass: restart, pulse sampling, entry actions, transitions.
  function automatic olsup_pkg::out_item_t step_supervisor(input olsup_pkg::in_item_t req);
    olsup_pkg::out_item_t res;
    int        tol;
    int        ph;
    logic      in_band;
    logic      out_band;
    res = '0;
    if (req.restart) begin
      sup_next = olsup_pkg::StStartup;
      sup_cur  = olsup_pkg::StSetup;
    end

    if (req.pps_rise) begin
      latched_phase = req.phase_error;
      if (sup_cur == olsup_pkg::StLocked) begin
        dac_avg = dac_avg - (dac_avg >> 4) + (req.dac_sample >> 4);
      end
      if (pulse_secs != olsup_pkg::SecsMax) begin
        pulse_secs = pulse_secs + 16'd1;
      end
    end

    // Entry actions of a newly requested state.
    if (sup_cur != sup_next) begin
      case (sup_next)
        olsup_pkg::StStartup: begin
          blink = olsup_pkg::PatAllOn;
          res.dac_write = 1'b1;
          res.dac_word = '0;
          osc_ctrl = (settings.video_standard ? olsup_pkg::CtrlStd : 5'h00)
                     | olsup_pkg::CtrlReset | olsup_pkg::CtrlFast;
          dac_avg = settings.default_dac;
        end
        olsup_pkg::StSetup: blink = olsup_pkg::PatOff;
        olsup_pkg::StError: blink = olsup_pkg::PatAllOn;
        olsup_pkg::StFixed: begin
          blink = olsup_pkg::PatFixed;
          lock_seen = 1'b0;
          res.dac_write = 1'b1;
          res.dac_word = dac_avg;
          osc_ctrl = osc_ctrl | olsup_pkg::CtrlFixed;
        end
        olsup_pkg::StLocking: begin
          blink = olsup_pkg::PatLocking;
          lock_seen = 1'b0;
          osc_ctrl = (osc_ctrl & ~(olsup_pkg::CtrlReset | olsup_pkg::CtrlFixed))
                     | olsup_pkg::CtrlFast;
        end
        olsup_pkg::StLocked: begin
          blink = olsup_pkg::PatOff;
          lock_seen = 1'b1;
          osc_ctrl = osc_ctrl & ~(olsup_pkg::CtrlFast | olsup_pkg::CtrlFixed);
        end
        olsup_pkg::StLost: begin
          blink = olsup_pkg::PatLost;
          res.dac_write = 1'b1;
          res.dac_word = dac_avg;
          osc_ctrl = osc_ctrl | olsup_pkg::CtrlFixed;
        end
        olsup_pkg::StOutOfPhase: blink = olsup_pkg::PatOop;
        olsup_pkg::StHoldFixed: begin
          blink = olsup_pkg::PatAllOn;
          lock_seen = 1'b0;
          osc_ctrl = osc_ctrl | olsup_pkg::CtrlFixed;
        end
        default: ;
      endcase
      pulse_secs = '0;
      sup_cur = sup_next;
    end

    // Transitions, judged on the latched phase.
    tol = int'(settings.phase_tolerance);
    ph = int'(latched_phase);
    in_band = (ph < tol) && (ph > -tol);
    out_band = (ph > tol) || (ph < -tol);
    case (sup_cur)
      olsup_pkg::StStartup: sup_next = olsup_pkg::StSetup;
      olsup_pkg::StSetup: begin
        if (pulse_secs > settings.setup_wait) begin
          sup_next = req.setup_ok ? olsup_pkg::StFixed : olsup_pkg::StError;
        end
      end
      olsup_pkg::StError: sup_next = olsup_pkg::StError;
      olsup_pkg::StFixed: begin
        if (!req.timepulse_ok) begin
          pulse_secs = '0;
        end else if (pulse_secs > settings.valid_wait) begin
          sup_next = olsup_pkg::StLocking;
        end
      end
      olsup_pkg::StLocking: begin
        if (!req.timepulse_ok) begin
          sup_next = olsup_pkg::StFixed;
        end else if (in_band) begin
          if (pulse_secs > settings.lock_seconds) sup_next = olsup_pkg::StLocked;
        end else begin
          pulse_secs = '0;
        end
      end
      olsup_pkg::StLocked: begin
        if (!req.timepulse_ok) sup_next = olsup_pkg::StLost;
        else if (out_band) sup_next = olsup_pkg::StOutOfPhase;
      end
      olsup_pkg::StLost: begin
        if (req.timepulse_ok) sup_next = olsup_pkg::StLocked;
        else if (pulse_secs > settings.hold_limit) sup_next = olsup_pkg::StHoldFixed;
      end
      olsup_pkg::StOutOfPhase: begin
        if (in_band) sup_next = olsup_pkg::StLocked;
        else if (!req.timepulse_ok) sup_next = olsup_pkg::StLost;
        else if (pulse_secs > settings.hold_limit) sup_next = olsup_pkg::StLocking;
      end
      olsup_pkg::StHoldFixed: begin
        if (req.timepulse_ok) sup_next = olsup_pkg::StLocking;
      end
      default: sup_next = olsup_pkg::StError;
    endcase

    res.sup_state = sup_cur;
    res.osc_control = osc_ctrl;
    res.control_write = req.pps_rise;
    res.locked_flag = lock_seen;
    res.avg_dac = dac_avg;
    res.blink_pattern = blink;
    return res;
  endfunction

  // Settings mirror follows every accepted register write.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      settings.phase_tolerance = olsup_pkg::PhaseTolReset;
      settings.lock_seconds = olsup_pkg::LockSecsReset;
      settings.hold_limit = 17'(olsup_pkg::LockSecsReset) * 17'd10;
      settings.default_dac = olsup_pkg::DefaultDacReset;
      settings.video_standard = olsup_pkg::VideoStdReset;
      settings.setup_wait = olsup_pkg::SetupWaitReset;
      settings.valid_wait = olsup_pkg::ValidWaitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        olsup_pkg::CfgPhaseTol: settings.phase_tolerance = cfg_data_i[14:0];
        olsup_pkg::CfgLockSecs: begin
          settings.lock_seconds = cfg_data_i[12:0];
          settings.hold_limit = 17'(cfg_data_i[12:0]) * 17'd10;
        end
        olsup_pkg::CfgDefaultDac: settings.default_dac = cfg_data_i;
        olsup_pkg::CfgVideoStd: settings.video_standard = cfg_data_i[0];
        olsup_pkg::CfgSetupWait: settings.setup_wait = cfg_data_i[7:0];
        olsup_pkg::CfgValidWait: settings.valid_wait = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Request driver: predicts on acceptance, then offers the next pass.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sup_cur <= olsup_pkg::StSetup;
      sup_next <= olsup_pkg::StStartup;
      pulse_secs <= '0;
      latched_phase <= '0;
      dac_avg <= '0;
      osc_ctrl <= '0;
      lock_seen <= 1'b0;
      blink <= '0;
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        status_due.push_back(step_supervisor(in_data_i));
        items_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pass_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= pass_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result monitor with random back-pressure.
  always @(posedge clk_i) begin
    olsup_pkg::out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (status_due.size() == 0) begin
          $error("status result with no pass outstanding");
          mismatches++;
        end else begin
          want = status_due.pop_front();
          check_field("sup_state", want.sup_state, out_data_o.sup_state);
          check_field("osc_control", want.osc_control, out_data_o.osc_control);
          check_field("control_write", want.control_write, out_data_o.control_write);
          check_field("locked_flag", want.locked_flag, out_data_o.locked_flag);
          check_field("dac_write", want.dac_write, out_data_o.dac_write);
          check_field("dac_word", want.dac_word, out_data_o.dac_word);
          check_field("avg_dac", want.avg_dac, out_data_o.avg_dac);
          check_field("blink_pattern", want.blink_pattern, out_data_o.blink_pattern);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic olsup_pkg::in_item_t make_req(input logic pps, input logic tp,
                                                   input logic [15:0] ph,
                                                   input logic [15:0] dac, input logic ok,
                                                   input logic rs);
    olsup_pkg::in_item_t r;
    r.pps_rise = pps;
    r.timepulse_ok = tp;
    r.phase_error = ph;
    r.dac_sample = dac;
    r.setup_ok = ok;
    r.restart = rs;
    return r;
  endfunction

  // Queue filling is done away from the rising edge.
  task automatic enqueue(input olsup_pkg::in_item_t r);
    pass_queue.push_back(r);
    items_queued++;
  endtask

  task automatic drain_results();
    do @(negedge clk_i); while (items_taken != items_queued || status_due.size() != 0);
  endtask

  // Register write with random junk above the field width; the block keeps
  // only the low bits.
  task automatic put_reg(input logic [olsup_pkg::CfgIdxW-1:0] idx, input int unsigned val,
                         input int unsigned w);
    int unsigned keep;
    keep = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 16'(($urandom() & ~keep) | (val & keep));
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Writes every register, plus one write to an unused index past the end of the list.
  task automatic load_settings(input int unsigned tol, input int unsigned lock,
                               input int unsigned dac, input int unsigned std,
                               input int unsigned swait, input int unsigned vwait);
    @(posedge clk_i);
    put_reg(olsup_pkg::CfgPhaseTol, tol, $bits(settings.phase_tolerance));
    put_reg(olsup_pkg::CfgLockSecs, lock, $bits(settings.lock_seconds));
    put_reg(olsup_pkg::CfgDefaultDac, dac, $bits(settings.default_dac));
    put_reg(olsup_pkg::CfgVideoStd, std, $bits(settings.video_standard));
    put_reg(olsup_pkg::CfgSetupWait, swait, $bits(settings.setup_wait));
    put_reg(olsup_pkg::CfgValidWait, vwait, $bits(settings.valid_wait));
    put_reg(olsup_pkg::CfgIdxW'(olsup_pkg::CfgValidWait + 1 + $urandom_range(1)),
            $urandom(), olsup_pkg::CfgDataW);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // A restart followed by segments of healthy tracking, timepulse dropouts,
  // phase excursions and plain noise.
  task automatic add_episode(input int unsigned n);
    int unsigned kind;
    int unsigned left;
    int          tol;
    int          near;
    logic        ok_always;
    logic        pps;
    logic        ok;
    left = 0;
    kind = 0;
    tol = int'(settings.phase_tolerance);
    ok_always = ($urandom_range(99) < 85);
    enqueue(make_req(1'($urandom_range(1)), 1'b1, 16'($urandom()), 16'($urandom()),
                     1'b1, 1'b1));
    repeat (n) begin
      if (left == 0) begin
        kind = $urandom_range(99);
        left = $urandom_range(1, (kind >= 50 && kind < 90) ? 40 : 12);
      end
      left--;
      pps = ($urandom_range(99) < 70);
      ok = ok_always ? 1'b1 : 1'($urandom_range(1));
      near = int'($urandom_range(0, 2 * tol + 2)) - (tol + 1);
      if (kind < 50) begin
        enqueue(make_req(pps, 1'b1, 16'(near), 16'($urandom()), ok, 1'b0));
      end else if (kind < 70) begin
        enqueue(make_req(pps, 1'b0, 16'(near), 16'($urandom()), ok, 1'b0));
      end else if (kind < 90) begin
        enqueue(make_req(pps, 1'b1, 16'($urandom()), 16'($urandom()), ok, 1'b0));
      end else begin
        enqueue(make_req(1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom()),
                         16'($urandom()), 1'($urandom_range(1)),
                         $urandom_range(7) == 0));
      end
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned tol;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero tolerance, no waits, full-scale default word, NTSC: setup failure,
    // the error state, restart and a locking attempt that can never lock.
    load_settings(0, 0, 16'hFFFF, 1, 0, 0);
    enqueue(make_req(1'b1, 1'b1, 16'h8000, 16'h0000, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b1, 16'h7FFF, 16'hFFFF, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b0, 16'h0000, 16'hFFFF, 1'b0, 1'b0));
    enqueue(make_req(1'b0, 1'b1, 16'hFFFF, 16'h0000, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b1, 16'h0001, 16'h1234, 1'b1, 1'b0));
    enqueue(make_req(1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b1));
    enqueue(make_req(1'b1, 1'b1, 16'h0000, 16'hA5A5, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b1, 16'h0000, 16'h5A5A, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b1, 16'h0000, 16'hFFFF, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b1, 16'h0000, 16'h0000, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b1, 16'h0000, 16'h8000, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b0, 16'h0000, 16'h7FFF, 1'b1, 1'b0));
    drain_results();

    // Widest tolerance: lock, then the band edges, out of phase, lost and
    // holdover with a zero holdover limit.
    load_settings(32767, 0, 0, 0, 0, 0);
    enqueue(make_req(1'b1, 1'b1, 16'h7FFE, 16'hFFFF, 1'b1, 1'b1));
    enqueue(make_req(1'b1, 1'b1, 16'h0000, 16'hFFFF, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b1, 16'h0000, 16'hFFFF, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b1, 16'h0000, 16'hFFFF, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b1, 16'h0000, 16'hFFFF, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b1, 16'h7FFE, 16'hFFFF, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b1, 16'h8001, 16'hFFFF, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b1, 16'h0000, 16'hFFFF, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b1, 16'h8000, 16'hFFFF, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b1, 16'h7FFF, 16'hFFFF, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b0, 16'h7FFF, 16'h0000, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0));
    enqueue(make_req(1'b1, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0));
    enqueue(make_req(1'b0, 1'b1, 16'h0000, 16'h0000, 1'b1, 1'b0));
    drain_results();

    // Random episodes under each idle mix, two settings per mix. Some
    // episodes start only after every outstanding result has come back.
    for (int mix = 0; mix < 4; mix++) begin
      send_idle_pct = SendIdle[mix];
      recv_stall_pct = RecvStall[mix];
      for (int half = 0; half < 2; half++) begin
        case ($urandom_range(9))
          0: tol = 0;
          1: tol = 1;
          2: tol = 32767;
          default: tol = $urandom_range(1, 300);
        endcase
        load_settings(tol, $urandom_range(0, 4), $urandom(), $urandom_range(1),
                      $urandom_range(0, 3), $urandom_range(0, 3));
        target = items_queued + 20;
        while (items_queued < target) begin
          if ($urandom_range(3) == 0) drain_results();
          add_episode($urandom_range(8, 40));
        end
        drain_results();
      end
    end

    // Longest setup wait with the narrowest tolerance that can lock, ending locked.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_settings(1, 0, 0, 0, 255, 40);
    enqueue(make_req(1'b1, 1'b1, 16'h0000, 16'($urandom()), 1'b1, 1'b1));
    repeat (305) enqueue(make_req(1'b1, 1'b1, 16'h0000, 16'($urandom()), 1'b1, 1'b0));
    drain_results();

    repeat (10) @(posedge clk_i);
    if (status_due.size() != 0) begin
      $error("%0d status results never arrived", status_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
